// ===== rtl/receive_reorder_window_top_assert.svh =====
// Assertion macros shared by the receive reorder window RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef RECEIVE_REORDER_WINDOW_TOP_ASSERT_SVH
`define RECEIVE_REORDER_WINDOW_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RRW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RRW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define RRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/rrw_pkg.sv =====
// Package for the receive reorder window: payload structs, status codes,
// controller state and command/status types. No dependencies.
`default_nettype none

package rrw_pkg;

  localparam int SEQ_BITS    = 32;
  localparam int TAG_BITS    = 16;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_OUTSIDE   = 3'd1,
    ST_DUP       = 3'd2,
    ST_OLD       = 3'd3,
    ST_INVALID   = 3'd4,
    ST_DELIVERED = 3'd5,
    ST_NONE      = 3'd6
  } rrw_status_t;

  typedef struct packed {
    logic                kind;
    logic [SEQ_BITS-1:0] seq_number;
    logic [TAG_BITS-1:0] packet_handle;
  } rrw_in_t;

  typedef struct packed {
    rrw_status_t         status;
    logic [TAG_BITS-1:0] out_handle;
    logic                ack_valid;
    logic [SEQ_BITS-1:0] ack_seq;
    logic [SEQ_BITS-1:0] cumulative_ack;
    logic                last;
  } rrw_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_DRD,
    S_DLD,
    S_WAIT_END,
    S_WAIT_MORE
  } rrw_state_t;

  typedef struct packed {
    logic accept;
    logic add_eval;
    logic drain_read;
    logic drain_none;
    logic drain_load;
  } rrw_cmd_t;

  typedef struct packed {
    logic in_drain;
    logic head_full;
    logic deliver_last;
    logic out_taken;
    logic out_valid;
  } rrw_sts_t;

endpackage

`default_nettype wire

// ===== rtl/receive_reorder_window_top.sv =====
// Receive reorder window top level: joins controller and datapath.
// Depends on rrw_pkg, rrw_ctrl, rrw_datapath (and rrw_ram below it).
//
// Usage:
//  - Input channel in_valid/in_stall/in_data carries add and drain transactions.
//    An add parks a packet handle in the window if it is new and in range, and yields one result.
//    A drain returns parked handles in sequence order, up to 32 results,
//    or one "nothing ready" result; the final result has last set.
//  - Result channel out_valid/out_stall/out_data; every result carries the
//    cumulative ack.
//  - One transaction is worked on at a time; in_stall is high until its
//    final result has been taken.
//  - Sequencing: an accepted add is registered, evaluated in S_ADD and its
//    result loaded into the output register; a drain with nothing ready loads
//    its result from S_DRD, otherwise each handle is read from the tag RAM
//    (registered read) in S_DRD and loaded into the single output register in
//    S_DLD; the next handle is read only after the current result is taken.
//  - A stall on the result channel holds the result and pauses the drain.
//  - Synchronous reset empties the window and sets the next expected number
//    to zero; no clearing pass is needed.
`default_nettype none

module receive_reorder_window_top #(
  parameter int WINDOW_DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rrw_pkg::rrw_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rrw_pkg::rrw_out_t      out_data
);
  import rrw_pkg::*;

  rrw_cmd_t cmd;
  rrw_sts_t sts;

  rrw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrw_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/rrw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rrw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/rrw_ctrl.sv =====
// Controller FSM of the receive reorder window: sequences add and drain
// transactions. Depends on rrw_pkg and the assertion header.
`default_nettype none
`include "receive_reorder_window_top_assert.svh"

module rrw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rrw_pkg::rrw_sts_t sts,
  output rrw_pkg::rrw_cmd_t      cmd
);
  import rrw_pkg::*;

  rrw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_drain ? S_DRD : S_ADD;
        end
      end
      S_ADD:  state_nxt = S_WAIT_END;
      S_DRD:  state_nxt = sts.head_full ? S_DLD : S_WAIT_END;
      S_DLD:  state_nxt = sts.deliver_last ? S_WAIT_END : S_WAIT_MORE;
      S_WAIT_END: begin
        if (sts.out_taken) begin
          state_nxt = S_IDLE;
        end
      end
      S_WAIT_MORE: begin
        if (sts.out_taken) begin
          state_nxt = S_DRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_ADD: cmd.add_eval = 1'b1;
      S_DRD: begin
        cmd.drain_read = sts.head_full;
        cmd.drain_none = !sts.head_full;
      end
      S_DLD: cmd.drain_load = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

  `RRW_ASSERT_IMPL(a_idle_out_empty, clk, rst_n, state_r == S_IDLE, !sts.out_valid, "result pending while idle")

endmodule

`default_nettype wire

// ===== rtl/rrw_datapath.sv =====
// Datapath of the receive reorder window: window state, slot valid bits,
// tag RAM and output register. Depends on rrw_pkg, rrw_ram, assertion header.
`default_nettype none
`include "receive_reorder_window_top_assert.svh"

module rrw_datapath #(
  parameter int WINDOW_DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rrw_pkg::rrw_cmd_t cmd,
  output rrw_pkg::rrw_sts_t      sts,
  input  wire rrw_pkg::rrw_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rrw_pkg::rrw_out_t      out_data
);
  import rrw_pkg::*;

  localparam int                   IDX_W     = $clog2(WINDOW_DEPTH);
  localparam logic [IDX_W:0]       DEPTH_W   = (IDX_W + 1)'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [SEQ_BITS-1:0]  DEPTH_SEQ = SEQ_BITS'(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0]     CNT_MAX   = CNT_W'(MAX_RESULTS);

  rrw_in_t                 item_r;
  logic [SEQ_BITS-1:0]     ne_r, ne_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [WINDOW_DEPTH-1:0] full_r, full_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  rrw_out_t                out_r, out_nxt;

  logic [SEQ_BITS-1:0] diff, ne_inc;
  logic [IDX_W:0]      slot_sum;
  logic [IDX_W-1:0]    slot, head_inc;
  logic                is_invalid, is_old, is_outside, is_dup, do_store;
  logic                next_full, deliver_last, out_taken;
  logic [CNT_W-1:0]    cnt_inc;
  logic [TAG_BITS-1:0] ram_rdata;

  // slot = seq mod depth, derived from the head slot since seq - ne < depth
  always_comb begin
    diff       = item_r.seq_number - ne_r;
    is_invalid = &item_r.seq_number;
    is_old     = item_r.seq_number < ne_r;
    is_outside = diff >= DEPTH_SEQ;
    slot_sum   = {1'b0, head_r} + {1'b0, diff[IDX_W-1:0]};
    slot       = (slot_sum >= DEPTH_W) ? IDX_W'(slot_sum - DEPTH_W) : slot_sum[IDX_W-1:0];
    is_dup     = full_r[slot];
    do_store   = cmd.add_eval && !is_invalid && !is_old && !is_outside && !is_dup;
  end

  // head follows ne mod depth; ne wrapping to zero puts it back at slot zero
  always_comb begin
    ne_inc = ne_r + 1'b1;
    if (&ne_r) begin
      head_inc = '0;
    end else if (head_r == LAST_IDX) begin
      head_inc = '0;
    end else begin
      head_inc = head_r + 1'b1;
    end
    cnt_inc      = cnt_r + 1'b1;
    next_full    = full_r[head_inc] && (head_inc != head_r);
    deliver_last = (cnt_inc == CNT_MAX) || !next_full;
    out_taken    = out_valid_r && !out_stall;
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.add_eval) begin
      out_nxt                = '0;
      out_nxt.cumulative_ack = ne_r;
      out_nxt.last           = 1'b1;
      if (is_invalid) begin
        out_nxt.status     = ST_INVALID;
        out_nxt.out_handle = item_r.packet_handle;
      end else if (is_old) begin
        out_nxt.status     = ST_OLD;
        out_nxt.out_handle = item_r.packet_handle;
        out_nxt.ack_valid  = 1'b1;
        out_nxt.ack_seq    = item_r.seq_number;
      end else if (is_outside) begin
        out_nxt.status     = ST_OUTSIDE;
        out_nxt.out_handle = item_r.packet_handle;
      end else if (is_dup) begin
        out_nxt.status     = ST_DUP;
        out_nxt.out_handle = item_r.packet_handle;
        out_nxt.ack_valid  = 1'b1;
        out_nxt.ack_seq    = item_r.seq_number;
      end else begin
        out_nxt.status    = ST_STORED;
        out_nxt.ack_valid = 1'b1;
        out_nxt.ack_seq   = item_r.seq_number;
      end
    end else if (cmd.drain_none) begin
      out_nxt                = '0;
      out_nxt.status         = ST_NONE;
      out_nxt.cumulative_ack = ne_r;
      out_nxt.last           = 1'b1;
    end else if (cmd.drain_load) begin
      out_nxt                = '0;
      out_nxt.status         = ST_DELIVERED;
      out_nxt.out_handle     = ram_rdata;
      out_nxt.ack_seq        = ne_r;
      out_nxt.cumulative_ack = ne_inc;
      out_nxt.last           = deliver_last;
    end
  end

  always_comb begin
    full_nxt      = full_r;
    ne_nxt        = ne_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (do_store) begin
      full_nxt[slot] = 1'b1;
    end
    if (cmd.drain_load) begin
      full_nxt[head_r] = 1'b0;
      ne_nxt           = ne_inc;
      head_nxt         = head_inc;
      cnt_nxt          = cnt_inc;
    end
    if (cmd.accept) begin
      cnt_nxt = '0;
    end
    if (out_taken) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.add_eval || cmd.drain_none || cmd.drain_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r      <= '0;
      ne_r        <= '0;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      full_r      <= full_nxt;
      ne_r        <= ne_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  rrw_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (do_store),
    .waddr (slot),
    .wdata (item_r.packet_handle),
    .re    (cmd.drain_read),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.in_drain     = (in_data.kind == KIND_DRAIN);
    sts.head_full    = full_r[head_r];
    sts.deliver_last = deliver_last;
    sts.out_taken    = out_taken;
    sts.out_valid    = out_valid_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `RRW_ASSERT_NEXT(a_ne_step, clk, rst_n, cmd.drain_load, ne_r == $past(ne_r) + 1'b1, "ne did not advance by one on delivery")
  `RRW_ASSERT_IMPL(a_load_full, clk, rst_n, cmd.drain_load, full_r[head_r], "delivery from an empty slot")
  `RRW_ASSERT_IMPL(a_cnt_cap, clk, rst_n, cmd.drain_read, cnt_r < CNT_MAX, "drain beyond result cap")

endmodule

`default_nettype wire
